/* rtl/djap_pkg.sv */
package djap_pkg;

	localparam int CoordWidth = 16;
	localparam int CoordFrac  = CoordWidth - 3;
	localparam int CoefWidth  = 16;
	localparam int CountWidth = 20;
	localparam int FrameWidth = 21;
	localparam int TrigIter   = 16;
	localparam int IterWidth  = $clog2(TrigIter);
	localparam int CfgWidth   = 21;
	localparam int CfgIdxWidth = 3;

	// angle registers are Q.24 with enough headroom for the products
	localparam int AngWidth  = 34;
	localparam int CorWidth  = 34;
	localparam int ProdWidth = CoefWidth + CoordWidth;

	// angle reduction: bias by 2^(RedSteps-1) turns, then one conditional
	// subtraction of 16, 8, 4, 2 and 1 turns per cycle
	localparam int RedSteps = 5;
	localparam int RedWidth = $clog2(RedSteps + 1);

	localparam logic signed [AngWidth-1:0] PiA     = 34'sd52707179;
	localparam logic signed [AngWidth-1:0] TwoPiA  = 34'sd105414357;
	localparam logic signed [AngWidth-1:0] HalfPiA = 34'sd26353589;
	localparam logic signed [AngWidth-1:0] AngBias = TwoPiA <<< (RedSteps - 1);
	localparam logic signed [CorWidth-1:0] CordicGain = 34'sd652032874;
	localparam logic signed [17:0] TrigOne = 18'sd16384;

	localparam logic [CfgIdxWidth-1:0] RegCoefA  = 3'd0;
	localparam logic [CfgIdxWidth-1:0] RegCoefB  = 3'd1;
	localparam logic [CfgIdxWidth-1:0] RegCoefC  = 3'd2;
	localparam logic [CfgIdxWidth-1:0] RegCoefD  = 3'd3;
	localparam logic [CfgIdxWidth-1:0] RegFrame  = 3'd4;
	localparam logic [CfgIdxWidth-1:0] RegStartX = 3'd5;
	localparam logic [CfgIdxWidth-1:0] RegStartY = 3'd6;

	function automatic logic [AngWidth-1:0] atan_step(input logic [IterWidth-1:0] i);
		logic [AngWidth-1:0] r;
		begin
			case (i)
				4'd0:  r = 34'd13176795;
				4'd1:  r = 34'd7778716;
				4'd2:  r = 34'd4110060;
				4'd3:  r = 34'd2086331;
				4'd4:  r = 34'd1047214;
				4'd5:  r = 34'd524117;
				4'd6:  r = 34'd262123;
				4'd7:  r = 34'd131069;
				4'd8:  r = 34'd65536;
				4'd9:  r = 34'd32768;
				4'd10: r = 34'd16384;
				4'd11: r = 34'd8192;
				4'd12: r = 34'd4096;
				4'd13: r = 34'd2048;
				4'd14: r = 34'd1024;
				default: r = 34'd512;
			endcase
			return r;
		end
	endfunction

	typedef struct packed {
		logic load;     // take a new angle and start
		logic [1:0] sel; // which of the four evaluations
	} djap_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;     // registered flag: the last cordic step has been taken
	} djap_stat_t;

endpackage

/* rtl/djap_ctrl.sv */
module djap_ctrl
	import djap_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_go,
	input  djap_stat_t stat,
	output djap_cmd_t  cmd,
	output logic       step_done
);

	typedef enum logic [2:0] {
		IDLE = 3'b001,
		RUN  = 3'b010,
		NEXT = 3'b100
	} state_t;

	state_t state_q;
	logic [1:0] sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			sel_q <= '0;
		end else begin
			unique case (state_q)
				IDLE: if (in_go) begin
					state_q <= NEXT;
					sel_q <= '0;
				end
				NEXT: state_q <= RUN;
				RUN: if (stat.done) begin
					if (sel_q == 2'd3) state_q <= IDLE;
					else begin
						sel_q <= sel_q + 2'd1;
						state_q <= NEXT;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.load = (state_q == NEXT);
		cmd.sel = sel_q;
		step_done = (state_q == RUN) && stat.done && (sel_q == 2'd3);
	end

`ifndef SYNTHESIS
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !stat.busy) else $error("load while cordic busy");
	a_done_run: assert property (@(posedge clk) disable iff (!arst_n)
		step_done |=> state_q == IDLE) else $error("step end not idle");
	a_next_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == NEXT |=> state_q == RUN) else $error("load not followed by run");
`endif

endmodule

/* rtl/djap_dp.sv */
module djap_dp
	import djap_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  djap_cmd_t cmd,
	output djap_stat_t stat,
	input  logic signed [CoefWidth-1:0] coef_a,
	input  logic signed [CoefWidth-1:0] coef_b,
	input  logic signed [CoefWidth-1:0] coef_c,
	input  logic signed [CoefWidth-1:0] coef_d,
	input  logic signed [CoordWidth-1:0] cx,
	input  logic signed [CoordWidth-1:0] cy,
	output logic signed [17:0] s1,
	output logic signed [17:0] c1,
	output logic signed [17:0] s2,
	output logic signed [17:0] c2
);

	logic signed [CoefWidth-1:0] coef;
	logic signed [CoordWidth-1:0] crd;
	logic signed [ProdWidth-1:0] prod;
	logic signed [AngWidth-1:0] ang, red_sub, r1, r2;
	logic neg0;

	logic signed [CorWidth-1:0] x_q, y_q;
	logic signed [AngWidth-1:0] r_q;
	logic neg_q, busy_q;
	logic [IterWidth-1:0] it_q;
	logic [RedWidth-1:0] red_q;
	logic fold_q;
	logic [1:0] sel_q;
	logic signed [17:0] s_res, c_res;

	always_comb begin
		case (cmd.sel)
			2'd0: begin coef = coef_a; crd = cy; end
			2'd1: begin coef = coef_b; crd = cx; end
			2'd2: begin coef = coef_c; crd = cx; end
			default: begin coef = coef_d; crd = cy; end
		endcase
		prod = coef * crd;
		// product is Q.24 directly; the bias of 16 turns keeps the angle positive
		ang = AngWidth'(prod) + AngBias;
		// turns taken off in this reduction cycle: 16, 8, 4, 2, then 1
		red_sub = TwoPiA <<< (red_q - RedWidth'(1));
		// fold the reduced angle into +-pi/2
		r1 = r_q;
		if (r1 > PiA) r1 = r1 - TwoPiA;
		neg0 = 1'b0;
		r2 = r1;
		if (r1 > HalfPiA) begin r2 = r1 - PiA; neg0 = 1'b1; end
		else if (r1 < -HalfPiA) begin r2 = r1 + PiA; neg0 = 1'b1; end
	end

	function automatic logic signed [17:0] to_trig(input logic signed [CorWidth-1:0] v,
		input logic ng);
		logic signed [CorWidth-1:0] t;
		logic signed [17:0] q;
		begin
			t = (v + 34'sd32768) >>> 16;
			if (t > 34'sd16384) q = TrigOne;
			else if (t < -34'sd16384) q = -TrigOne;
			else q = t[17:0];
			return ng ? -q : q;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			it_q <= '0;
			red_q <= '0;
			fold_q <= 1'b0;
		end else if (cmd.load) begin
			busy_q <= 1'b0;
			it_q <= '0;
			red_q <= RedWidth'(RedSteps);
			fold_q <= 1'b0;
		end else if (red_q != '0) begin
			red_q <= red_q - RedWidth'(1);
			if (red_q == RedWidth'(1)) fold_q <= 1'b1;
		end else if (fold_q) begin
			fold_q <= 1'b0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			it_q <= it_q + 1'b1;
			if (it_q == IterWidth'(TrigIter - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= CordicGain;
			y_q <= '0;
			r_q <= ang;
			sel_q <= cmd.sel;
		end else if (red_q != '0) begin
			if (r_q >= red_sub) r_q <= r_q - red_sub;
		end else if (fold_q) begin
			r_q <= r2;
			neg_q <= neg0;
		end else if (busy_q) begin
			if (r_q >= 0) begin
				x_q <= x_q - (y_q >>> it_q);
				y_q <= y_q + (x_q >>> it_q);
				r_q <= r_q - atan_step(it_q);
			end else begin
				x_q <= x_q + (y_q >>> it_q);
				y_q <= y_q - (x_q >>> it_q);
				r_q <= r_q + atan_step(it_q);
			end
		end
	end

	assign s_res = to_trig(y_q, neg_q);
	assign c_res = to_trig(x_q, neg_q);

	// results captured in the cycle after the last step, while fin_q is high
	logic fin_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fin_q <= 1'b0;
		else fin_q <= busy_q && (it_q == IterWidth'(TrigIter - 1));
	end

	always_ff @(posedge clk) begin
		if (fin_q) begin
			case (sel_q)
				2'd0: s1 <= s_res;
				2'd1: c1 <= c_res;
				2'd2: s2 <= s_res;
				default: c2 <= c_res;
			endcase
		end
	end

	assign stat.busy = busy_q || fin_q || fold_q || (red_q != '0);
	assign stat.done = fin_q;

endmodule

/* rtl/de_jong_attractor_point_generator.sv */
// De Jong attractor point generator: each accepted transaction (restart flag)
// produces one point x' = sin(a*y) - cos(b*x), y' = sin(c*x) - cos(d*y), Q3.13,
// with frame_end on the last point of each frame. The four sine/cosine values
// come one after another from a single datapath: each goes through a load,
// five angle-reduction steps, one fold, 16 CORDIC steps and a capture; the
// next transaction is taken once the result has left the output register.
module de_jong_attractor_point_generator
	import djap_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CfgIdxWidth-1:0] cfg_index,
	input  logic [CfgWidth-1:0] cfg_data,
	input  logic valid_in,
	output logic stall_in,
	input  logic restart,
	output logic valid_out,
	input  logic stall_out,
	output logic signed [CoordWidth-1:0] point_x,
	output logic signed [CoordWidth-1:0] point_y,
	output logic frame_end
);

	logic signed [CoefWidth-1:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q;
	logic [FrameWidth-1:0] frame_q;
	logic signed [CoordWidth-1:0] start_x_q, start_y_q, cx_q, cy_q;
	logic [CountWidth-1:0] cnt_q;
	logic busy_q;
	logic in_go, step_done;
	djap_cmd_t cmd;
	djap_stat_t stat;
	logic signed [17:0] s1, c1, s2, c2;
	logic signed [18:0] dx, dy;
	logic signed [CoordWidth-1:0] nx, ny;
	logic [FrameWidth-1:0] len;
	logic end_w;

	assign stall_in = busy_q || valid_out;
	assign in_go = valid_in && !stall_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= -16'sd13865;
			coef_b_q <= -16'sd17900;
			coef_c_q <= -16'sd17797;
			coef_d_q <= -16'sd8847;
			frame_q <= 21'd524288;
			start_x_q <= 16'sd8;
			start_y_q <= 16'sd8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegCoefA:  coef_a_q <= cfg_data[CoefWidth-1:0];
				RegCoefB:  coef_b_q <= cfg_data[CoefWidth-1:0];
				RegCoefC:  coef_c_q <= cfg_data[CoefWidth-1:0];
				RegCoefD:  coef_d_q <= cfg_data[CoefWidth-1:0];
				RegFrame:  frame_q <= cfg_data[FrameWidth-1:0];
				RegStartX: start_x_q <= cfg_data[CoordWidth-1:0];
				RegStartY: start_y_q <= cfg_data[CoordWidth-1:0];
				default: ;
			endcase
		end
	end

	djap_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(in_go), .stat(stat),
		.cmd(cmd), .step_done(step_done)
	);

	djap_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.coef_a(coef_a_q), .coef_b(coef_b_q), .coef_c(coef_c_q), .coef_d(coef_d_q),
		.cx(cx_q), .cy(cy_q), .s1(s1), .c1(c1), .s2(s2), .c2(c2)
	);

	// the last cosine lands in the cycle after step_done, so fin_q registers step_done
	logic fin_q;

	always_comb begin
		dx = 19'(s1) - 19'(c1);
		dy = 19'(s2) - 19'(c2);
		nx = CoordWidth'((dx + 19'sd1) >>> 1);
		ny = CoordWidth'((dy + 19'sd1) >>> 1);
		// frame length clamped to 1 .. 2^CountWidth
		if (frame_q == '0) len = FrameWidth'(1);
		else if (frame_q > (FrameWidth'(1) << CountWidth)) len = FrameWidth'(1) << CountWidth;
		else len = frame_q;
		end_w = {1'b0, cnt_q} >= len - FrameWidth'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			valid_out <= 1'b0;
			cx_q <= 16'sd8;
			cy_q <= 16'sd8;
			cnt_q <= '0;
		end else begin
			fin_q <= step_done;
			if (valid_out && !stall_out) valid_out <= 1'b0;
			if (in_go) begin
				busy_q <= 1'b1;
				if (restart) begin
					cx_q <= start_x_q;
					cy_q <= start_y_q;
					cnt_q <= '0;
				end
			end
			if (fin_q) begin
				busy_q <= 1'b0;
				valid_out <= 1'b1;
				cx_q <= nx;
				cy_q <= ny;
				cnt_q <= end_w ? '0 : cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_q) begin
			point_x <= nx;
			point_y <= ny;
			frame_end <= end_w;
		end
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !in_go) else $error("transaction accepted mid step");
	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> busy_q) else $error("result without a step");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> valid_out) else $error("result not presented");
`endif

endmodule
